@@ design/rotation_matrix_to_quaternion_macros.svh @@
// Assertion macros for the rotation matrix to quaternion block.
// Used by design/rotation_matrix_to_quaternion.sv; expects clk and rst_n in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// check that a condition implies a consequence in the same cycle
`define RMQ_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// check that a condition implies a consequence in the next cycle
`define RMQ_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rmq_pkg.sv @@
// Shared types for the rotation matrix to quaternion block.
// No dependencies.
`default_nettype none

package rmq_pkg;

    localparam int unsigned DIFF_W = 18;
    localparam int unsigned MAG_W  = 17;
    localparam int unsigned QUO_W  = 17;
    localparam int unsigned LANES  = 3;

    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } sel_t;

    typedef logic signed [DIFF_W-1:0] diff_t;

    typedef struct packed {
        sel_t  sel;
        diff_t da;
        diff_t db;
        diff_t dc;
    } carry_t;

endpackage

`default_nettype wire

@@ design/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion (Shepperd's method) as a valid/stall pipeline.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_macros.svh.
//
// One item enters per cycle while in_stall is low; it passes stage A, stage B,
// the root stages, stage C, the scaling stages and the output stage. SW is the
// root width, ceil((max(FRAC_BITS,17) + 1 + FRAC_BITS) / 2) (16 stages of root
// at FRAC_BITS = 14). The square root takes one result bit per stage, each of
// the three reciprocal scalings one quotient bit per stage. Each stage holds its
// item until the next stage is free, so bubbles close up under a stalled output.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int unsigned FRAC_BITS = 14
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] col0_row0,
    input  wire logic signed [15:0] col0_row1,
    input  wire logic signed [15:0] col0_row2,
    input  wire logic signed [15:0] col1_row0,
    input  wire logic signed [15:0] col1_row1,
    input  wire logic signed [15:0] col1_row2,
    input  wire logic signed [15:0] col2_row0,
    input  wire logic signed [15:0] col2_row1,
    input  wire logic signed [15:0] col2_row2,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w
);

    localparam int unsigned TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int unsigned SW  = (TW + FRAC_BITS + 1) / 2;
    localparam int unsigned XW  = 2 * SW;
    localparam int unsigned DW  = SW + 2;
    localparam int unsigned QW  = rmq_pkg::QUO_W;
    localparam int unsigned MW  = rmq_pkg::MAG_W;
    localparam int unsigned NW  = MW + FRAC_BITS + 1;
    localparam int unsigned NL  = rmq_pkg::LANES;
    localparam int unsigned P_C = 2 + SW;
    localparam int unsigned P_O = P_C + QW + 1;
    localparam int unsigned NS  = P_O + 1;

    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;

    always_comb
    begin
        ld[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign in_stall  = !ld[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // stage A: trace combinations and off-diagonal sums
    rmq_pkg::diff_t cw_reg, cx_reg, cy_reg, cz_reg;
    rmq_pkg::diff_t p01_reg, m01_reg, p20_reg, m20_reg, p12_reg, m12_reg;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            cw_reg  <= 18'(col0_row0) + 18'(col1_row1) + 18'(col2_row2);
            cx_reg  <= 18'(col0_row0) - 18'(col1_row1) - 18'(col2_row2);
            cy_reg  <= 18'(col1_row1) - 18'(col0_row0) - 18'(col2_row2);
            cz_reg  <= 18'(col2_row2) - 18'(col0_row0) - 18'(col1_row1);
            p01_reg <= 18'(col0_row1) + 18'(col1_row0);
            m01_reg <= 18'(col0_row1) - 18'(col1_row0);
            p20_reg <= 18'(col2_row0) + 18'(col0_row2);
            m20_reg <= 18'(col2_row0) - 18'(col0_row2);
            p12_reg <= 18'(col1_row2) + 18'(col2_row1);
            m12_reg <= 18'(col1_row2) - 18'(col2_row1);
        end
    end

    // stage B: pick the largest combination, earliest wins a tie
    rmq_pkg::diff_t best;
    rmq_pkg::carry_t b_next;
    logic [TW-1:0] b_t_reg;
    rmq_pkg::carry_t b_c_reg;

    always_comb
    begin
        best       = cw_reg;
        b_next.sel = rmq_pkg::SEL_W;
        if (cx_reg > best)
        begin
            best       = cx_reg;
            b_next.sel = rmq_pkg::SEL_X;
        end
        if (cy_reg > best)
        begin
            best       = cy_reg;
            b_next.sel = rmq_pkg::SEL_Y;
        end
        if (cz_reg > best)
        begin
            best       = cz_reg;
            b_next.sel = rmq_pkg::SEL_Z;
        end
        unique case (b_next.sel)
            rmq_pkg::SEL_W:
            begin
                b_next.da = m12_reg;
                b_next.db = m20_reg;
                b_next.dc = m01_reg;
            end
            rmq_pkg::SEL_X:
            begin
                b_next.da = p01_reg;
                b_next.db = p20_reg;
                b_next.dc = m12_reg;
            end
            rmq_pkg::SEL_Y:
            begin
                b_next.da = p01_reg;
                b_next.db = p12_reg;
                b_next.dc = m20_reg;
            end
            default:
            begin
                b_next.da = p20_reg;
                b_next.db = p12_reg;
                b_next.dc = m01_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            b_t_reg <= TW'(best[16:0]) + (TW'(1) << FRAC_BITS);
            b_c_reg <= b_next;
        end
    end

    // square root, one result bit per stage
    logic [XW-1:0]   sx_reg [SW];
    logic [XW-1:0]   sr_reg [SW];
    rmq_pkg::carry_t sc_reg [SW];

    for (genvar j = 0; j < SW; j++)
    begin : g_sqrt
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (SW - 1 - j));
        logic [XW-1:0]   x_in;
        logic [XW-1:0]   r_in;
        logic [XW-1:0]   trial;
        logic [XW-1:0]   x_next;
        logic [XW-1:0]   r_next;
        rmq_pkg::carry_t c_in;

        always_comb
        begin
            if (j == 0)
            begin
                x_in = XW'(b_t_reg) << FRAC_BITS;
                r_in = '0;
                c_in = b_c_reg;
            end
            else
            begin
                x_in = sx_reg[j-1];
                r_in = sr_reg[j-1];
                c_in = sc_reg[j-1];
            end
            trial = r_in + BIT;
            if (x_in >= trial)
            begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[2+j])
            begin
                sx_reg[j] <= x_next;
                sr_reg[j] <= r_next;
                sc_reg[j] <= c_in;
            end
        end
    end

    // stage C: biggest component, magnitudes and signs
    logic [SW:0]     root_inc;
    logic [SW-1:0]   cbig_reg;
    logic [MW-1:0]   cmag_reg [NL];
    logic [NL-1:0]   cneg_reg;
    rmq_pkg::sel_t   csel_reg;
    rmq_pkg::diff_t  c_d [NL];

    assign root_inc = (SW+1)'(sr_reg[SW-1]) + (SW+1)'(1);
    assign c_d[0]   = sc_reg[SW-1].da;
    assign c_d[1]   = sc_reg[SW-1].db;
    assign c_d[2]   = sc_reg[SW-1].dc;

    always_ff @(posedge clk)
    begin
        if (ld[P_C])
        begin
            cbig_reg <= root_inc[SW:1];
            csel_reg <= sc_reg[SW-1].sel;
            for (int l = 0; l < NL; l++)
            begin
                cneg_reg[l] <= c_d[l][rmq_pkg::DIFF_W-1];
                cmag_reg[l] <= c_d[l][rmq_pkg::DIFF_W-1] ? MW'(-c_d[l]) : MW'(c_d[l]);
            end
        end
    end

    // scaling by 0.25 / biggest, one quotient bit per stage
    logic [DW-1:0]   dr_reg   [QW][NL];
    logic [QW-1:0]   dl_reg   [QW][NL];
    logic [QW-1:0]   dq_reg   [QW][NL];
    logic [NL-1:0]   dn_reg   [QW];
    logic [SW-1:0]   dbig_reg [QW];
    rmq_pkg::sel_t   dsel_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        logic [DW-1:0] den;
        logic [DW-1:0] r_in   [NL];
        logic [QW-1:0] l_in   [NL];
        logic [QW-1:0] q_in   [NL];
        logic [DW:0]   r_sh   [NL];
        logic [DW-1:0] r_next [NL];
        logic [QW-1:0] q_next [NL];
        logic [NW-1:0] num    [NL];
        logic [SW-1:0] big_in;
        logic [NL-1:0] n_in;
        rmq_pkg::sel_t sel_in;

        always_comb
        begin
            big_in = (s == 0) ? cbig_reg : dbig_reg[s-1];
            n_in   = (s == 0) ? cneg_reg : dn_reg[s-1];
            sel_in = (s == 0) ? csel_reg : dsel_reg[s-1];
            den    = DW'(big_in) << 2;
            for (int l = 0; l < NL; l++)
            begin
                num[l] = (NW'(cmag_reg[l]) << FRAC_BITS) + (NW'(cbig_reg) << 1);
                if (s == 0)
                begin
                    r_in[l] = DW'(num[l][NW-1:QW]);
                    l_in[l] = num[l][QW-1:0];
                    q_in[l] = '0;
                end
                else
                begin
                    r_in[l] = dr_reg[s-1][l];
                    l_in[l] = dl_reg[s-1][l];
                    q_in[l] = dq_reg[s-1][l];
                end
                r_sh[l] = {r_in[l], l_in[l][QW-1]};
                if (r_sh[l] >= {1'b0, den})
                begin
                    r_next[l] = DW'(r_sh[l] - {1'b0, den});
                    q_next[l] = {q_in[l][QW-2:0], 1'b1};
                end
                else
                begin
                    r_next[l] = DW'(r_sh[l]);
                    q_next[l] = {q_in[l][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[P_C+1+s])
            begin
                dbig_reg[s] <= big_in;
                dn_reg[s]   <= n_in;
                dsel_reg[s] <= sel_in;
                for (int l = 0; l < NL; l++)
                begin
                    dr_reg[s][l] <= r_next[l];
                    dl_reg[s][l] <= l_in[l] << 1;
                    dq_reg[s][l] <= q_next[l];
                end
            end
        end
    end

    // output stage: sign, saturate, place components
    logic signed [15:0] sat_big;
    logic signed [15:0] sat_q [NL];
    logic signed [15:0] quat_x_reg, quat_y_reg, quat_z_reg, quat_w_reg;

    always_comb
    begin
        if (dbig_reg[QW-1] > SW'(32767))
        begin
            sat_big = 16'sd32767;
        end
        else
        begin
            sat_big = 16'(dbig_reg[QW-1]);
        end
        for (int l = 0; l < NL; l++)
        begin
            if (dn_reg[QW-1][l])
            begin
                if (dq_reg[QW-1][l] > QW'(32768))
                begin
                    sat_q[l] = -16'sd32768;
                end
                else
                begin
                    sat_q[l] = 16'(-dq_reg[QW-1][l]);
                end
            end
            else if (dq_reg[QW-1][l] > QW'(32767))
            begin
                sat_q[l] = 16'sd32767;
            end
            else
            begin
                sat_q[l] = 16'(dq_reg[QW-1][l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[P_O])
        begin
            unique case (dsel_reg[QW-1])
                rmq_pkg::SEL_W:
                begin
                    quat_x_reg <= sat_q[0];
                    quat_y_reg <= sat_q[1];
                    quat_z_reg <= sat_q[2];
                    quat_w_reg <= sat_big;
                end
                rmq_pkg::SEL_X:
                begin
                    quat_x_reg <= sat_big;
                    quat_y_reg <= sat_q[0];
                    quat_z_reg <= sat_q[1];
                    quat_w_reg <= sat_q[2];
                end
                rmq_pkg::SEL_Y:
                begin
                    quat_x_reg <= sat_q[0];
                    quat_y_reg <= sat_big;
                    quat_z_reg <= sat_q[1];
                    quat_w_reg <= sat_q[2];
                end
                default:
                begin
                    quat_x_reg <= sat_q[0];
                    quat_y_reg <= sat_q[1];
                    quat_z_reg <= sat_big;
                    quat_w_reg <= sat_q[2];
                end
            endcase
        end
    end

    assign quat_x = quat_x_reg;
    assign quat_y = quat_y_reg;
    assign quat_z = quat_z_reg;
    assign quat_w = quat_w_reg;

`include "rotation_matrix_to_quaternion_macros.svh"

    `RMQ_ASSERT_NEXT(a_enter, in_valid && !in_stall, v_reg[0], "accepted item not captured")
    `RMQ_ASSERT_NOW(a_full, in_stall, &v_reg, "input stalled with a free stage")
    `RMQ_ASSERT_NOW(a_big_min, v_reg[P_C], cbig_reg >= (SW'(1) << (FRAC_BITS - 1)),
        "biggest component below one half")
    `RMQ_ASSERT_NOW(a_quo_max, v_reg[P_O-1], dq_reg[QW-1][0] <= QW'(32768),
        "scaled component out of range")

endmodule

`default_nettype wire

@@ test/tb_rotation_matrix_to_quaternion.sv @@
// Testbench for rotation_matrix_to_quaternion: directed and random matrices,
// results checked against an in-bench Shepperd predictor. Depends on rmq_pkg.
`timescale 1ns / 100ps
`default_nettype none

module tb_rotation_matrix_to_quaternion;

    localparam int FRAC = 14;
    localparam int NUM_RANDOM = 1330;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [15:0] elem_t;
    typedef struct packed {
        elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } matrix_t;
    typedef struct packed {
        elem_t x, y, z, w;
    } quat_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    elem_t col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2;
    elem_t col2_row0, col2_row1, col2_row2;
    elem_t quat_x, quat_y, quat_z, quat_w;

    matrix_t pending_mats[$];
    quat_t expected_quats[$];
    int mismatches;
    bit stim_done;
    longint cycles;

    rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint scaled(longint d, longint unsigned big);
        longint unsigned mag, q;
        mag = (d < 0) ? longint'(-d) : d;
        q = ((mag << FRAC) + big * 2) / (big * 4);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic elem_t clamp16(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return elem_t'(v);
    endfunction

    function automatic quat_t shepperd_quat(matrix_t m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint cw, cx, cy, cz, best, qx, qy, qz, qw;
        longint unsigned big;
        rmq_pkg::sel_t sel;
        quat_t q;
        a00 = m.m00; a01 = m.m01; a02 = m.m02;
        a10 = m.m10; a11 = m.m11; a12 = m.m12;
        a20 = m.m20; a21 = m.m21; a22 = m.m22;
        cw = a00 + a11 + a22;
        cx = a00 - a11 - a22;
        cy = a11 - a00 - a22;
        cz = a22 - a00 - a11;
        sel = rmq_pkg::SEL_W;
        best = cw;
        if (cx > best)
        begin
            best = cx;
            sel = rmq_pkg::SEL_X;
        end
        if (cy > best)
        begin
            best = cy;
            sel = rmq_pkg::SEL_Y;
        end
        if (cz > best)
        begin
            best = cz;
            sel = rmq_pkg::SEL_Z;
        end
        big = (int_sqrt(longint'(best + (64'sd1 << FRAC)) << FRAC) + 1) >> 1;
        case (sel)
            rmq_pkg::SEL_W:
            begin
                qx = scaled(a12 - a21, big);
                qy = scaled(a20 - a02, big);
                qz = scaled(a01 - a10, big);
                qw = big;
            end
            rmq_pkg::SEL_X:
            begin
                qx = big;
                qy = scaled(a01 + a10, big);
                qz = scaled(a20 + a02, big);
                qw = scaled(a12 - a21, big);
            end
            rmq_pkg::SEL_Y:
            begin
                qx = scaled(a01 + a10, big);
                qy = big;
                qz = scaled(a12 + a21, big);
                qw = scaled(a20 - a02, big);
            end
            default:
            begin
                qx = scaled(a20 + a02, big);
                qy = scaled(a12 + a21, big);
                qz = big;
                qw = scaled(a01 - a10, big);
            end
        endcase
        q.x = clamp16(qx);
        q.y = clamp16(qy);
        q.z = clamp16(qz);
        q.w = clamp16(qw);
        return q;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
            2: return elem_t'($urandom_range(0, 32768) - 16384);
            default: return elem_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        real a, b, c, r[9];
        int i;
        if ($urandom_range(0, 3) == 0)
        begin
            m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                 rand_elem(), rand_elem(), rand_elem(), rand_elem()};
            return m;
        end
        a = $urandom_range(0, 62831) / 10000.0;
        b = $urandom_range(0, 62831) / 10000.0;
        c = $urandom_range(0, 62831) / 10000.0;
        r[0] = $cos(a) * $cos(b);
        r[1] = $sin(a) * $cos(b);
        r[2] = -$sin(b);
        r[3] = $cos(a) * $sin(b) * $sin(c) - $sin(a) * $cos(c);
        r[4] = $sin(a) * $sin(b) * $sin(c) + $cos(a) * $cos(c);
        r[5] = $cos(b) * $sin(c);
        r[6] = $cos(a) * $sin(b) * $cos(c) + $sin(a) * $sin(c);
        r[7] = $sin(a) * $sin(b) * $cos(c) - $cos(a) * $sin(c);
        r[8] = $cos(b) * $cos(c);
        for (i = 0; i < 9; i++)
            m[(8 - i) * 16 +: 16] = elem_t'($rtoi(r[i] * 16384.0)
                                            + int'($urandom_range(0, 8)) - 4);
        return m;
    endfunction

    initial
    begin
        elem_t one, neg;
        one = 16'sd16384;
        neg = -16'sd16384;
        pending_mats.push_back({one, 16'sd0, 16'sd0, 16'sd0, one, 16'sd0, 16'sd0, 16'sd0, one});
        pending_mats.push_back({one, 16'sd0, 16'sd0, 16'sd0, neg, 16'sd0, 16'sd0, 16'sd0, neg});
        pending_mats.push_back({neg, 16'sd0, 16'sd0, 16'sd0, one, 16'sd0, 16'sd0, 16'sd0, neg});
        pending_mats.push_back({neg, 16'sd0, 16'sd0, 16'sd0, neg, 16'sd0, 16'sd0, 16'sd0, one});
        pending_mats.push_back('0);
        pending_mats.push_back({9{16'h7fff}});
        pending_mats.push_back({9{16'h8000}});
        pending_mats.push_back({9{16'hffff}});
        pending_mats.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                                16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
        pending_mats.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                                16'h8000, 16'h7fff, 16'h8000, 16'h8000});
        pending_mats.push_back({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
                                16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        pending_mats.push_back({one, one, 16'sd0, one, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
        pending_mats.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                16'sd0, 16'sd0, neg});
        pending_mats.push_back({16'sd0, 16'h5555, 16'haaaa, 16'haaaa, 16'sd0, 16'h5555,
                                16'h5555, 16'haaaa, 16'sd0});
        pending_mats.push_back({neg, 16'h7fff, 16'h7fff, 16'h8000, neg, 16'h7fff,
                                16'h8000, 16'h8000, neg});
        repeat (NUM_RANDOM)
            pending_mats.push_back(rand_matrix());
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
             col2_row0, col2_row1, col2_row2} <= '0;
            send_gap <= 0;
            stim_done <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            matrix_t m;
            if (in_valid)
                expected_quats.push_back(shepperd_quat({col0_row0, col0_row1, col0_row2,
                    col1_row0, col1_row1, col1_row2, col2_row0, col2_row1, col2_row2}));
            if (send_gap > 0 || pending_mats.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else
                    stim_done <= 1'b1;
            end
            else
            begin
                m = pending_mats.pop_front();
                in_valid <= 1'b1;
                {col0_row0, col0_row1, col0_row2, col1_row0, col1_row1, col1_row2,
                 col2_row0, col2_row1, col2_row2} <= m;
                send_gap <= gap_length();
            end
        end
    end

    int stall_len;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_len <= 0;
            mismatches <= 0;
        end
        else
        begin
            quat_t got, want;
            if (out_valid && !out_stall)
            begin
                got = {quat_x, quat_y, quat_z, quat_w};
                if (expected_quats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected quaternion %h", got);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_quats.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                            $display({"Mismatch: expected x=%0d y=%0d z=%0d w=%0d, ",
                                      "got x=%0d y=%0d z=%0d w=%0d"},
                                     want.x, want.y, want.z, want.w,
                                     got.x, got.y, got.z, got.w);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (stall_len > 0)
            begin
                stall_len <= stall_len - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_len <= gap_length();
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        cycles = 0;
        wait (rst_n === 1'b1);
        while (!(stim_done && expected_quats.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            repeat (80) @(posedge clk);
            if (mismatches == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end
endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/rmq_pkg.sv
design/rotation_matrix_to_quaternion.sv
test/tb_rotation_matrix_to_quaternion.sv
